// ===== sv/rvst_pkg.sv =====
// ----------------------------------------------------------------------------
// rvst_pkg
// Shared types and constants for the running variance stop test.
// ----------------------------------------------------------------------------
package rvst_pkg;

  // fixed field and state widths
  localparam int unsigned REG_W  = 32;   // configuration register width
  localparam int unsigned SMP_W  = 32;   // sample field width on the port
  localparam int unsigned MEAN_W = 48;   // running mean, Q32.16
  localparam int unsigned SUM_W  = 64;   // sum of squared deviations, Q64.0
  localparam int unsigned PROD_W = 192;  // limit * mean^2 * count^2
  localparam int unsigned FRAC_SHIFT = 16;  // Q32.0 sample to Q32.16 alignment

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_LIMIT_SQUARED = 2'd0,
    REG_MIN_SAMPLES   = 2'd1,
    REG_MAX_SAMPLES   = 2'd2,
    REG_MEAN_FLOOR    = 2'd3
  } reg_idx_t;

  // input actions
  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_CLEAR = 1'b1
  } action_t;

endpackage

// ===== sv/running_variance_stop_test.sv =====
// ----------------------------------------------------------------------------
// running_variance_stop_test
// Welford running mean and variance of a scalar sample stream, with a
// stop decision on the squared relative standard error of the mean.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  ------------------------------------
//  s_axis    in   s_tvalid / s_tready  s_tdata = sample, s_tuser = action
//  m_axis    out  m_tvalid / m_tready  m_tdata = keep_sampling, sample_count
//  cfg       in   cfg_we               cfg_addr, cfg_wdata
//
//  A clear is applied straight from the idle state. A sample runs a
//  48-step restoring divider for the mean step, then one shift-add
//  multiplier for the deviation product and, unless a count or mean
//  floor bound decides, the chain mean*mean*count*count*limit, one
//  multiplier bit per cycle (it stops early when the rest are zero).
//  s_tready is high only while the sequencer is idle; a finished result
//  waits in the output register, so a stalled m_tready holds the last
//  step. Reset loads the register defaults and clears the running state.
//
module running_variance_stop_test #(
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // [31:0] sample
  input  logic        s_tuser,     // [0] action
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,     // [0] keep_sampling, [32:1] sample_count
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  localparam int unsigned MW = rvst_pkg::MEAN_W;
  localparam int unsigned PW = rvst_pkg::PROD_W;
  localparam int unsigned SW = rvst_pkg::SUM_W;
  localparam int unsigned CW = COUNT_WIDTH;
  localparam logic [31:0] SAMPLE_MASK = (SAMPLE_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << SAMPLE_WIDTH) - 64'd1);
  localparam logic [5:0]  DIV_STEPS = 6'(MW);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_UPD, S_DEV, S_SUM, S_SQ, S_CNT1, S_CNT2, S_LIM, S_CMP, S_OUT
  } state_t;

  state_t          state;
  // configuration
  logic [31:0]     limit_squared, min_samples, max_samples, mean_floor;
  // running state
  logic [CW-1:0]   count;
  logic [MW-1:0]   running_mean;
  logic [SW-1:0]   sum_squares;
  // per-item work registers
  logic [MW-1:0]   val;
  logic [MW-1:0]   diff;
  logic            ge;
  logic [MW-1:0]   dq;       // dividend shifting out, quotient shifting in
  logic [CW-1:0]   rem;
  logic [5:0]      step;
  logic [PW-1:0]   acc, mcand;
  logic [MW-1:0]   mplier;
  logic            keep;

  // input decode
  logic [MW-1:0]   val_in;
  assign val_in = {MW'(s_tdata & SAMPLE_MASK)} << rvst_pkg::FRAC_SHIFT;
  assign s_tready = (state == S_IDLE);

  // divider step
  logic [CW:0]     rem_sh, rem_sub;
  assign rem_sh  = {rem, dq[MW-1]};
  assign rem_sub = rem_sh - {1'b0, count};

  // mean update and second deviation
  logic [MW-1:0]   mean_upd, d2;
  assign mean_upd = ge ? running_mean + dq : running_mean - dq;
  assign d2 = (val >= mean_upd) ? val - mean_upd : mean_upd - val;

  // sum update with saturation
  logic [SW:0]     sum_add;
  assign sum_add = {1'b0, sum_squares} + {1'b0, acc[95:32]};

  // shift-add multiplier step
  logic [PW-1:0]   acc_step;
  assign acc_step = mplier[0] ? acc + mcand : acc;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      limit_squared <= '0;
      min_samples   <= '0;
      max_samples   <= 32'hFFFF_FFFF;
      mean_floor    <= 32'd1;
      count         <= '0;
      running_mean  <= '0;
      sum_squares   <= '0;
      m_tvalid      <= 1'b0;
      m_tdata       <= '0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        unique case (rvst_pkg::reg_idx_t'(cfg_addr))
          rvst_pkg::REG_LIMIT_SQUARED: limit_squared <= cfg_wdata;
          rvst_pkg::REG_MIN_SAMPLES:   min_samples   <= cfg_wdata;
          rvst_pkg::REG_MAX_SAMPLES:   max_samples   <= cfg_wdata;
          rvst_pkg::REG_MEAN_FLOOR:    mean_floor    <= cfg_wdata;
          default: ;
        endcase
      end
      // output step reloads m_tvalid itself
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (rvst_pkg::action_t'(s_tuser) == rvst_pkg::ACT_CLEAR) begin
              count        <= '0;
              running_mean <= '0;
              sum_squares  <= '0;
            end else begin
              if (count != {CW{1'b1}}) count <= count + 1'b1;
              val   <= val_in;
              ge    <= (val_in >= running_mean);
              diff  <= (val_in >= running_mean) ? val_in - running_mean
                                                : running_mean - val_in;
              dq    <= (val_in >= running_mean) ? val_in - running_mean
                                                : running_mean - val_in;
              rem   <= '0;
              step  <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!rem_sub[CW]) begin
            rem <= rem_sub[CW-1:0];
            dq  <= {dq[MW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[CW-1:0];
            dq  <= {dq[MW-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == DIV_STEPS - 1'b1) state <= S_UPD;
        end
        S_UPD: begin
          running_mean <= mean_upd;
          acc    <= '0;
          mcand  <= PW'(diff);
          mplier <= d2;
          state  <= S_DEV;
        end
        S_DEV, S_SQ, S_CNT1, S_CNT2, S_LIM: begin
          if (mplier != '0) begin
            acc    <= acc_step;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            // next link of the chain; the deviation and the final product
            // stay in acc for the sum and the compare
            if (state inside {S_SQ, S_CNT1, S_CNT2}) acc <= '0;
            mcand <= acc;
            unique case (state)
              S_DEV:   state <= S_SUM;
              S_SQ:  begin mplier <= MW'(count);         state <= S_CNT1; end
              S_CNT1: begin mplier <= MW'(count);        state <= S_CNT2; end
              S_CNT2: begin mplier <= MW'(limit_squared); state <= S_LIM; end
              default: state <= S_CMP;
            endcase
          end
        end
        S_SUM: begin
          sum_squares <= sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
          if (32'(count) < min_samples) begin
            keep  <= 1'b1;
            state <= S_OUT;
          end else if (32'(count) >= max_samples) begin
            keep  <= 1'b0;
            state <= S_OUT;
          end else if (running_mean < ({16'd0, mean_floor} << rvst_pkg::FRAC_SHIFT)) begin
            keep  <= 1'b0;
            state <= S_OUT;
          end else begin
            acc    <= '0;
            mcand  <= PW'(running_mean);
            mplier <= running_mean;
            state  <= S_SQ;
          end
        end
        S_CMP: begin
          keep  <= !({64'd0, sum_squares, 64'd0} < acc);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, 32'(count), keep};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // divider never sees a zero count
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> count != '0) else $error("divide by zero count");

  // remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < count) else $error("divider remainder out of range");

  // a clear zeroes all running state
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=>
      count == '0 && running_mean == '0 && sum_squares == '0)
    else $error("clear left state behind");

  // a result is loaded only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT) else $error("stray result");

endmodule

// ===== test/tb_running_variance_stop_test.sv =====
// ----------------------------------------------------------------------------
// tb_running_variance_stop_test
// Drives sample and clear transfers into the running variance stop test,
// predicts every decision with a wide-integer Welford model and compares
// each result transfer against it, under several register settings and
// random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_running_variance_stop_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        keep;
    logic [31:0] count;
  } decision_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // predictor state and register copies
  logic [31:0] lim_sq, min_smp, max_smp, floor_q;
  logic [31:0] n_smp;
  logic [47:0] mean_q;
  logic [63:0] sumsq_q;

  decision_t   pending_decisions[$];
  int          send_idle_pct, recv_idle_pct;
  int          watchdog;
  bit          failed;

  always #1 clk = ~clk;

  running_variance_stop_test uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_wdata
  );

  // Welford update and stop decision, exact wide arithmetic
  function automatic void predict_welford(input logic [31:0] smp);
    logic [63:0]  v, q, d1, d2;
    logic [47:0]  nm;
    logic [127:0] prod;
    logic [255:0] rhs, lhs;
    logic [64:0]  s;
    logic         keep;
    v = {32'd0, smp} << 16;
    if (n_smp != 32'hFFFF_FFFF) n_smp = n_smp + 1;
    if (v >= mean_q) begin
      q  = (v - mean_q) / n_smp;
      nm = mean_q + q[47:0];
    end else begin
      q  = (mean_q - v) / n_smp;
      nm = mean_q - q[47:0];
    end
    d1 = (v >= mean_q) ? v - mean_q : mean_q - v;
    d2 = (v >= nm) ? v - nm : nm - v;
    mean_q = nm;
    prod = d1 * d2;
    s = sumsq_q + prod[95:32];
    sumsq_q = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    if (n_smp < min_smp) keep = 1'b1;
    else if (n_smp >= max_smp) keep = 1'b0;
    else if ({16'd0, mean_q} < ({32'd0, floor_q} << 16)) keep = 1'b0;
    else begin
      rhs = 256'(mean_q) * 256'(mean_q) * 256'(n_smp) * 256'(n_smp) * 256'(lim_sq);
      lhs = 256'(sumsq_q) << 64;
      keep = (lhs < rhs) ? 1'b0 : 1'b1;
    end
    pending_decisions.push_back('{keep, n_smp});
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    decision_t exp_d;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_decisions.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          failed = 1'b1;
        end else begin
          exp_d = pending_decisions.pop_front();
          if (m_tdata[0] !== exp_d.keep) begin
            $display("%0t: keep_sampling expected %0d actual %0d",
                     $time, exp_d.keep, m_tdata[0]);
            failed = 1'b1;
          end
          if (m_tdata[32:1] !== exp_d.count) begin
            $display("%0t: sample_count expected %0d actual %0d",
                     $time, exp_d.count, m_tdata[32:1]);
            failed = 1'b1;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("tb_running_variance_stop_test failed");
      $finish;
    end
  end

  // tvalid stays high after a transfer until the next item or an idle cycle
  task automatic send_item(input rvst_pkg::action_t act, input logic [31:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    if (act == rvst_pkg::ACT_CLEAR) begin
      n_smp = '0; mean_q = '0; sumsq_q = '0;
    end else predict_welford(smp);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes
  task automatic write_reg(input rvst_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      rvst_pkg::REG_LIMIT_SQUARED: lim_sq  = val;
      rvst_pkg::REG_MIN_SAMPLES:   min_smp = val;
      rvst_pkg::REG_MAX_SAMPLES:   max_smp = val;
      default:                     floor_q = val;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] l, mn, mx, f);
    drain();
    write_reg(rvst_pkg::REG_LIMIT_SQUARED, l);
    write_reg(rvst_pkg::REG_MIN_SAMPLES, mn);
    write_reg(rvst_pkg::REG_MAX_SAMPLES, mx);
    write_reg(rvst_pkg::REG_MEAN_FLOOR, f);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'h0001_0000 + $urandom_range(32'h0000_0FFF);
      2: return $urandom_range(3);
      default: return 32'h8000_0000 + $urandom_range(32'h000F_FFFF);
    endcase
  endfunction

  // fields at extremes, clear, zero mean with zero floor, defaults
  task automatic test_directed;
    send_item(rvst_pkg::ACT_ADD, 32'h0);
    send_item(rvst_pkg::ACT_ADD, 32'hFFFF_FFFF);
    send_item(rvst_pkg::ACT_ADD, 32'h0);
    send_item(rvst_pkg::ACT_ADD, 32'hFFFF_FFFF);
    send_item(rvst_pkg::ACT_CLEAR, 32'hFFFF_FFFF);
    set_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(rvst_pkg::ACT_ADD, 32'h0);
    send_item(rvst_pkg::ACT_ADD, 32'h0);
    send_item(rvst_pkg::ACT_CLEAR, 32'h0);
    set_regs(32'h0000_1000, 32'd3, 32'd6, 32'hFFFF_FFFF);
    repeat (4) send_item(rvst_pkg::ACT_ADD, 32'hFFFF_FFFF);
    send_item(rvst_pkg::ACT_CLEAR, 32'h0);
    set_regs(32'h0000_1000, 32'hFFFF_FFFF, 32'd0, 32'd1);
    repeat (3) send_item(rvst_pkg::ACT_ADD, 32'h5555_AAAA);
    send_item(rvst_pkg::ACT_CLEAR, 32'h0);
  endtask

  // random samples from one of four value modes, redrawn every 60 items,
  // with a clear in place of a sample about 3 percent of the time
  task automatic test_random(input int items);
    int mode;
    mode = 0;
    for (int i = 0; i < items; i++) begin
      if (i % 60 == 0) mode = $urandom_range(3);
      if ($urandom_range(99) < 3) send_item(rvst_pkg::ACT_CLEAR, $urandom());
      else send_item(rvst_pkg::ACT_ADD, rand_sample(mode));
    end
  endtask

  task automatic test_settings;
    set_regs(32'h0000_4000, 32'd5, 32'd40, 32'h0000_8000);
    test_random(170);
    set_regs(32'h0100_0000, 32'd0, 32'd1000, 32'd1);
    test_random(170);
    set_regs(32'd0, 32'd10, 32'hFFFF_FFFF, 32'd0);
    test_random(170);
    set_regs($urandom(), $urandom_range(20), $urandom_range(21, 300), $urandom_range(2));
    test_random(170);
  endtask

  initial begin
    failed = 1'b0;
    lim_sq = '0; min_smp = '0; max_smp = 32'hFFFF_FFFF; floor_q = 32'd1;
    n_smp = '0; mean_q = '0; sumsq_q = '0;
    send_idle_pct = 30;
    recv_idle_pct = 59;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    send_idle_pct = 59;
    recv_idle_pct = 30;
    test_random(75);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(75);
    drain();
    if (!failed) $display("tb_running_variance_stop_test passed");
    else $display("tb_running_variance_stop_test failed");
    $finish;
  end

endmodule
